@@ rtl/fat12_pkg.sv @@
// shared constants for the fat12 allocation table engine
package fat12_pkg;

    localparam int ENTRY_COUNT_DEF = 4096;

    localparam int CMD_W    = 3;
    localparam int CLUSTER_W = 12;
    localparam int BYTE_W   = 8;
    localparam int BADDR_W  = 13;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_READ_ENTRY  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_ENTRY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FIND_FREE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_BYTE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_WRITE_BYTE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED    = 2'd3;

endpackage

@@ rtl/fat12_table_engine.sv @@
// fat12 allocation table engine: packed table image in two byte banks with entry and byte access
//
// The table image of (3*ENTRY_COUNT+1)/2 bytes is split into an even-byte bank and an odd-byte
// bank, so the two bytes of any entry are read together in the same cycle. After reset a
// clearing pass zeroes both banks one row per cycle; input stays stalled until it ends. Read
// entry, write entry, read byte, write byte and unused codes are each handled as one bank read,
// then decode or merge and write back. Find free examines entries from the start cluster
// upward, with the bank reads pipelined at one entry per cycle; a search that finds no free
// entry ends once the last entry has been checked. A finished result is held in an output
// register, and the next transfer is taken while it waits.
module fat12_table_engine
    import fat12_pkg::*;
#(
    parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_command,
    input  logic [CLUSTER_W-1:0]  i_cluster,
    input  logic [CLUSTER_W-1:0]  i_entry_value,
    input  logic [BADDR_W-1:0]    i_byte_address,
    input  logic [BYTE_W-1:0]     i_byte_value,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CLUSTER_W-1:0]  o_result_data,
    output logic [STATUS_W-1:0]   o_status
);

    localparam int TABLE_BYTES = (ENTRY_COUNT * 3 + 1) / 2;
    localparam int ROWS        = (TABLE_BYTES + 1) / 2;
    localparam int ROW_W       = $clog2(ROWS);
    localparam int N_W         = CLUSTER_W + 1;
    localparam logic [N_W-1:0]     EC_N      = N_W'(ENTRY_COUNT);
    localparam logic [BADDR_W:0]   TB_N      = (BADDR_W + 1)'(TABLE_BYTES);
    localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [BYTE_W-1:0]    r_mem0 [ROWS];
    logic [BYTE_W-1:0]    r_mem1 [ROWS];
    logic [BYTE_W-1:0]    r_q0;
    logic [BYTE_W-1:0]    r_q1;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [ROW_W-1:0]     r_clr;
    logic [CMD_W-1:0]     r_cmd;
    logic [CLUSTER_W-1:0] r_ev;
    logic [BYTE_W-1:0]    r_bv;
    logic                 r_ba0;
    logic                 r_bad;
    logic [ROW_W-1:0]     r_row0;
    logic [ROW_W-1:0]     r_row1;
    logic                 r_swap;
    logic                 r_odd;
    logic                 r_chk_v;
    logic [N_W-1:0]       r_chk_c;
    logic [N_W-1:0]       r_issue;
    logic [CLUSTER_W-1:0] r_res_data;
    logic [STATUS_W-1:0]  r_res_status;
    logic                 r_out_valid;
    logic [CLUSTER_W-1:0] r_out_data;
    logic [STATUS_W-1:0]  r_out_status;

    logic                 in_acc;
    logic                 out_free;
    logic                 rd_en;
    logic                 scan_rd;
    logic [N_W-1:0]       a_n;
    logic [BADDR_W-1:0]   a_pos;
    logic [ROW_W-1:0]     ra0;
    logic [ROW_W-1:0]     ra1;
    logic                 byte_cmd;
    logic [BYTE_W-1:0]    lo;
    logic [BYTE_W-1:0]    hi;
    logic [CLUSTER_W-1:0] val;
    logic [BYTE_W-1:0]    new_lo;
    logic [BYTE_W-1:0]    new_hi;
    logic                 we0;
    logic                 we1;
    logic [ROW_W-1:0]     wa0;
    logic [ROW_W-1:0]     wa1;
    logic [BYTE_W-1:0]    wd0;
    logic [BYTE_W-1:0]    wd1;
    logic                 fin;
    logic [CLUSTER_W-1:0] fin_data;
    logic [STATUS_W-1:0]  fin_status;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign byte_cmd   = (i_command == CMD_READ_BYTE) || (i_command == CMD_WRITE_BYTE);

    // read address: new transfer or next entry of a scan
    always_comb begin
        a_n   = (r_state == S_IDLE) ? {1'b0, i_cluster} : r_issue;
        a_pos = BADDR_W'(a_n + {1'b0, a_n[N_W-1:1]});
        if ((r_state == S_IDLE) && byte_cmd) begin
            ra0 = ROW_W'(i_byte_address[BADDR_W-1:1]);
            ra1 = ROW_W'(i_byte_address[BADDR_W-1:1]);
        end else begin
            ra0 = ROW_W'(a_pos[BADDR_W-1:1] + {{(BADDR_W-2){1'b0}}, a_pos[0]});
            ra1 = ROW_W'(a_pos[BADDR_W-1:1]);
        end
    end

    assign scan_rd = (r_state == S_SCAN) && r_chk_v && (val != '0) && (r_issue < EC_N);
    assign rd_en   = in_acc || scan_rd;

    // entry decode and nibble merge
    always_comb begin
        lo = r_swap ? r_q1 : r_q0;
        hi = r_swap ? r_q0 : r_q1;
        if (r_odd) begin
            val    = {hi, lo[7:4]};
            new_lo = {r_ev[3:0], lo[3:0]};
            new_hi = r_ev[11:4];
        end else begin
            val    = {hi[3:0], lo};
            new_lo = r_ev[7:0];
            new_hi = {hi[7:4], r_ev[11:8]};
        end
    end

    always_comb begin
        we0        = 1'b0;
        we1        = 1'b0;
        wa0        = r_row0;
        wa1        = r_row1;
        wd0        = r_swap ? new_hi : new_lo;
        wd1        = r_swap ? new_lo : new_hi;
        fin        = 1'b0;
        fin_data   = '0;
        fin_status = ST_OK;
        n_state    = r_state;
        case (r_state)
            S_CLEAR: begin
                we0 = 1'b1;
                we1 = 1'b1;
                wa0 = r_clr;
                wa1 = r_clr;
                wd0 = '0;
                wd1 = '0;
                if (r_clr == LAST_ROW) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_command == CMD_FIND_FREE) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                fin = 1'b1;
                case (r_cmd)
                    CMD_READ_ENTRY: begin
                        fin_data   = r_bad ? '0 : val;
                        fin_status = r_bad ? ST_BAD_ADDR : ST_OK;
                    end
                    CMD_WRITE_ENTRY: begin
                        we0        = !r_bad;
                        we1        = !r_bad;
                        fin_status = r_bad ? ST_BAD_ADDR : ST_OK;
                    end
                    CMD_READ_BYTE: begin
                        fin_data   = r_bad ? '0 : {4'b0, (r_ba0 ? r_q1 : r_q0)};
                        fin_status = r_bad ? ST_BAD_ADDR : ST_OK;
                    end
                    CMD_WRITE_BYTE: begin
                        we0        = !r_bad && !r_ba0;
                        we1        = !r_bad && r_ba0;
                        wd0        = r_bv;
                        wd1        = r_bv;
                        fin_status = r_bad ? ST_BAD_ADDR : ST_OK;
                    end
                    default: begin
                        fin_status = ST_OK;
                    end
                endcase
            end
            S_SCAN: begin
                if (!r_chk_v) begin
                    fin        = 1'b1;
                    fin_status = ST_NOT_FOUND;
                end else if (val == '0) begin
                    fin      = 1'b1;
                    fin_data = r_chk_c[CLUSTER_W-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[wa0] <= wd0;
        end
        if (rd_en) begin
            r_q0 <= r_mem0[ra0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[wa1] <= wd1;
        end
        if (rd_en) begin
            r_q1 <= r_mem1[ra1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_chk_v     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (in_acc) begin
                r_chk_v <= ({1'b0, i_cluster} < EC_N);
            end else if (scan_rd || (r_state == S_SCAN)) begin
                r_chk_v <= scan_rd;
            end
            if (fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_command;
            r_ev    <= i_entry_value;
            r_bv    <= i_byte_value;
            r_ba0   <= i_byte_address[0];
            r_bad   <= byte_cmd ? ({1'b0, i_byte_address} >= TB_N)
                                : ({1'b0, i_cluster} >= EC_N);
            r_chk_c <= {1'b0, i_cluster};
            r_issue <= {1'b0, i_cluster} + 1'b1;
        end else if (scan_rd) begin
            r_chk_c <= r_issue;
            r_issue <= r_issue + 1'b1;
        end
        if (rd_en) begin
            r_row0 <= ra0;
            r_row1 <= ra1;
            r_swap <= a_pos[0];
            r_odd  <= a_n[0];
        end
        if (fin) begin
            r_res_data   <= fin_data;
            r_res_status <= fin_status;
        end
        if (fin && out_free) begin
            r_out_data   <= fin_data;
            r_out_status <= fin_status;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_data   <= r_res_data;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_data = r_out_data;
    assign o_status      = r_out_status;

`ifndef ASSERT_OFF
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result during clearing pass");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE))
        else $error("engine idle right after input transfer");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_status != ST_UNUSED))
        else $error("unused status code on output");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_chk_v) |-> (r_chk_c < EC_N))
        else $error("scan checks entry past table");
`endif

endmodule
